// ----- src/cscm_pkg.sv -----
// ----------------------------------------------------------------------------
// cscm_pkg
// shared widths, constants, register codes and the command/status types
// between the controller and the datapath of the collatz step counter
// ----------------------------------------------------------------------------
package cscm_pkg;

    localparam int MEMO_DEPTH_DEF = 4096;
    localparam int TRAJ_WIDTH_DEF = 64;

    localparam int VAL_W     = 31;   // start value and range registers
    localparam int CNT_W     = 16;   // step count
    localparam int Q_W       = 27;   // value / 24 for values below 2^31
    localparam int CFG_IDX_W = 1;

    // x / 3 == (x * DIV3_MUL) >> DIV3_SHIFT, exact for x < 2^32
    localparam logic [31:0] DIV3_MUL   = 32'hAAAA_AAAB;
    localparam int          DIV3_SHIFT = 33;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // a memoized value is 10 mod 24: low three bits 010, upper part 1 mod 3
    localparam logic [2:0] MEMO_LOW3 = 3'b010;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_START = 1'b0,
        REG_RANGE_END   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic load;       // take a new start value
        logic step;       // one collatz step
        logic add_memo;   // add memo entry to the count
        logic restore;    // reload the walk value with the start value
        logic rd_en;      // read memo entry of the current value
        logic store;      // write the count to the memo entry of the current value
        logic out_load;   // capture result into the output register
        logic out_ovf;    // result is saturated
    } dp_cmd_t;

    typedef struct packed {
        logic clear_busy; // memo clearing pass in progress
        logic is_zero;
        logic is_one;
        logic cand;       // in range and low bits match
        logic qual;       // candidate with valid memo slot
        logic memo_nz;    // memo read data nonzero
        logic sum_ovf;    // count plus memo entry passes the count range
        logic step_ovf;   // next step saturates or leaves the trajectory width
    } dp_status_t;

endpackage

// ----- src/cscm_datapath.sv -----
// ----------------------------------------------------------------------------
// cscm_datapath
// walk value, step count, range registers, memo store with clearing pass,
// slot index arithmetic and the output register
// ----------------------------------------------------------------------------
module cscm_datapath
    import cscm_pkg::*;
#(
    parameter int MEMO_DEPTH = MEMO_DEPTH_DEF,
    parameter int TRAJ_WIDTH = TRAJ_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data,
    input  logic [VAL_W-1:0]     start_value,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    output logic [CNT_W-1:0]     step_count,
    output logic                 overflow
);

    localparam int AW = (MEMO_DEPTH > 1) ? $clog2(MEMO_DEPTH) : 1;
    localparam logic [TRAJ_WIDTH-1:0] VMAX      = '1;
    localparam logic [TRAJ_WIDTH-1:0] ODD_LIMIT = TRAJ_WIDTH'((VMAX - 1) / 3);
    localparam logic [Q_W-1:0]        DEPTH_Q   = Q_W'(MEMO_DEPTH);
    localparam logic [AW-1:0]         LAST_ADDR = AW'(MEMO_DEPTH - 1);

    logic [TRAJ_WIDTH-1:0] traj_reg, traj_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [VAL_W-1:0]      start_reg;
    logic [VAL_W-1:0]      range_start_reg, range_end_reg;
    logic [Q_W-1:0]        base_reg, q_reg;
    logic [CNT_W-1:0]      rd_data_reg;
    logic [CNT_W-1:0]      step_count_reg;
    logic                  overflow_reg;
    logic                  clear_busy_reg, clear_busy_next;
    logic [AW-1:0]         clear_addr_reg, clear_addr_next;

    logic [CNT_W-1:0]      memo_mem [MEMO_DEPTH];

    logic [VAL_W-1:0]      low_val;
    logic                  upper_zero;
    logic [27:0]           div8_val;
    logic [59:0]           q_prod;
    logic [31:0]           base_sum;
    logic [60:0]           base_prod;
    logic [27:0]           rem3;
    logic [Q_W-1:0]        slot_idx;
    logic [AW-1:0]         slot_addr;
    logic [CNT_W:0]        memo_sum;
    logic [TRAJ_WIDTH-1:0] triple_plus_one;

    // slot arithmetic
    assign low_val    = traj_reg[VAL_W-1:0];
    assign upper_zero = (traj_reg[TRAJ_WIDTH-1:VAL_W] == '0);
    assign div8_val   = low_val[VAL_W-1:3];
    assign q_prod     = 60'(div8_val) * 60'(DIV3_MUL);
    assign base_sum   = 32'(range_start_reg) + 32'd13;
    assign base_prod  = 61'(base_sum[31:3]) * 61'(DIV3_MUL);
    assign rem3       = div8_val - (28'(q_reg) << 1) - 28'(q_reg);
    assign slot_idx   = q_reg - base_reg;
    assign slot_addr  = slot_idx[AW-1:0];
    assign memo_sum   = {1'b0, count_reg} + {1'b0, rd_data_reg};
    assign triple_plus_one = traj_reg + (traj_reg << 1) + TRAJ_WIDTH'(1);

    always_comb
    begin
        status            = '0;
        status.clear_busy = clear_busy_reg;
        status.is_zero    = (traj_reg == '0);
        status.is_one     = (traj_reg == TRAJ_WIDTH'(1));
        status.cand       = upper_zero && (low_val >= range_start_reg)
                            && (low_val <= range_end_reg)
                            && (low_val[2:0] == MEMO_LOW3);
        status.qual       = status.cand && (rem3 == 28'd1) && (slot_idx < DEPTH_Q);
        status.memo_nz    = (rd_data_reg != '0);
        status.sum_ovf    = memo_sum[CNT_W];
        status.step_ovf   = (count_reg == COUNT_MAX)
                            || (traj_reg[0] && (traj_reg > ODD_LIMIT));
    end

    always_comb
    begin
        traj_next  = traj_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            traj_next  = TRAJ_WIDTH'(start_value);
            count_next = '0;
        end
        else if (cmd.step)
        begin
            traj_next  = traj_reg[0] ? triple_plus_one : (traj_reg >> 1);
            count_next = count_reg + CNT_W'(1);
        end
        else
        begin
            if (cmd.add_memo)
            begin
                count_next = memo_sum[CNT_W-1:0];
            end
            if (cmd.restore)
            begin
                traj_next = TRAJ_WIDTH'(start_reg);
            end
        end
    end

    always_comb
    begin
        clear_busy_next = clear_busy_reg;
        clear_addr_next = clear_addr_reg;
        if (cfg_we)
        begin
            clear_busy_next = 1'b1;
            clear_addr_next = '0;
        end
        else if (clear_busy_reg)
        begin
            clear_addr_next = clear_addr_reg + AW'(1);
            if (clear_addr_reg == LAST_ADDR)
            begin
                clear_busy_next = 1'b0;
                clear_addr_next = '0;
            end
        end
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg  <= 1'b1;
            clear_addr_reg  <= '0;
            range_start_reg <= VAL_W'(1);
            range_end_reg   <= VAL_W'(1);
        end
        else
        begin
            clear_busy_reg <= clear_busy_next;
            clear_addr_reg <= clear_addr_next;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_RANGE_START: range_start_reg <= cfg_data;
                    REG_RANGE_END:   range_end_reg   <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        traj_reg  <= traj_next;
        count_reg <= count_next;
        q_reg     <= q_prod[DIV3_SHIFT +: Q_W];
        base_reg  <= base_prod[DIV3_SHIFT +: Q_W];
        if (cmd.load)
        begin
            start_reg <= start_value;
        end
        if (cmd.out_load)
        begin
            step_count_reg <= cmd.out_ovf ? COUNT_MAX : count_reg;
            overflow_reg   <= cmd.out_ovf;
        end
    end

    // memo store: one write port shared by clearing pass and store, one read port
    always_ff @(posedge clk)
    begin
        if (clear_busy_reg)
        begin
            memo_mem[clear_addr_reg] <= '0;
        end
        else if (cmd.store)
        begin
            memo_mem[slot_addr] <= count_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= memo_mem[slot_addr];
        end
    end

    assign step_count = step_count_reg;
    assign overflow   = overflow_reg;

endmodule

// ----- src/cscm_ctrl.sv -----
// ----------------------------------------------------------------------------
// cscm_ctrl
// sequencer for one walk: step, memo probe and lookup, memo store, result
// handoff to the output register
// ----------------------------------------------------------------------------
module cscm_ctrl
    import cscm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PROBE,
        ST_LOOKUP,
        ST_SEVAL,
        ST_SPROBE,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   ovf_reg, ovf_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE) && !status.clear_busy;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    ovf_next   = 1'b0;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.is_zero)
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (status.is_one)
                begin
                    cmd.restore = 1'b1;
                    state_next  = ST_SEVAL;
                end
                else if (status.cand)
                begin
                    state_next = ST_PROBE;
                end
                else if (status.step_ovf)
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_PROBE:
            begin
                if (status.qual)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_LOOKUP;
                end
                else if (status.step_ovf)
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_LOOKUP:
            begin
                if (status.memo_nz)
                begin
                    if (status.sum_ovf)
                    begin
                        ovf_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.add_memo = 1'b1;
                        cmd.restore  = 1'b1;
                        state_next   = ST_SEVAL;
                    end
                end
                else if (status.step_ovf)
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_SEVAL:
            begin
                state_next = status.cand ? ST_SPROBE : ST_DONE;
            end
            ST_SPROBE:
            begin
                cmd.store  = status.qual;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_ovf    = ovf_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_store_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> !status.clear_busy)
        else $error("memo store during clearing pass");

    a_load_enters_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_EVAL))
        else $error("accepted transaction did not start a walk");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten before transaction");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result presented outside done state");

    a_read_needs_cand: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_en || cmd.store) |-> status.cand)
        else $error("memo access for a value that is not a candidate");
`endif

endmodule

// ----- src/collatz_step_counter_memo_core.sv -----
// ----------------------------------------------------------------------------
// collatz_step_counter_memo_core
// counts collatz steps of a start value down to 1, with a memo store of the
// counts of start values that are 10 mod 24 inside the configured range
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------
//  input     | in_valid / in_ready    | start_value[30:0]
//  output    | out_valid / out_ready  | step_count[15:0], overflow
//  config    | cfg_we (no wait)       | cfg_index[0:0], cfg_data[30:0]
//
//  walk: the sequencer steps the value, adds a slot check for each in-range
//    value that is 2 mod 8 met on the walk and a memo read through the
//    registered read port when that value has a memo slot; setup, memo store
//    and result handoff come on top
//  reset: a clearing pass writes every memo entry; the same pass runs after
//    every register write; no transaction is taken then
//  stalls: the result sits in an output register, so the next start value is
//    taken while it waits; a new result waits until the previous one is gone
//
module collatz_step_counter_memo_core
    import cscm_pkg::*;
#(
    parameter int MEMO_DEPTH = MEMO_DEPTH_DEF,
    parameter int TRAJ_WIDTH = TRAJ_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data,
    // start value channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [VAL_W-1:0]     start_value,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CNT_W-1:0]     step_count,
    output logic                 overflow
);

    // command and status between the sequencer and the datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: walk, memo probe, store and result handoff
    cscm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: walk value, count, range registers, memo store, output register
    cscm_datapath #(
        .MEMO_DEPTH (MEMO_DEPTH),
        .TRAJ_WIDTH (TRAJ_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start_value (start_value),
        .cmd         (cmd),
        .status      (status),
        .step_count  (step_count),
        .overflow    (overflow)
    );

endmodule
